// ----- src/prt_pkg.sv -----
// ----------------------------------------------------------------------------
// prt_pkg
// shared sizes, action codes and stage structs for the prefix routing table
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int DIGITS     = 8;
  localparam int NODE_BITS  = 10;
  localparam int HOP_BITS   = 8;

  localparam int ADDR_W     = 16;
  localparam int HOPS_IN_W  = 8;
  localparam int ID_W       = 2 * DIGITS;
  localparam int SLOTS      = DIGITS * 4;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int HOP_SUM_W  = ((HOPS_IN_W > HOP_BITS) ? HOPS_IN_W : HOP_BITS) + 1;
  localparam logic [HOP_SUM_W-1:0] HOP_SAT = HOP_SUM_W'((1 << HOP_BITS) - 1);

  typedef enum logic {
    ACT_OFFER  = 1'b0,
    ACT_LOOKUP = 1'b1
  } act_t;

  typedef struct packed {
    logic                 valid;
    act_t                 action;
    logic                 is_self;
    logic [SLOT_W-1:0]    slot;
    logic                 present;
    logic [HOPS_IN_W-1:0] hops;
    logic [NODE_BITS-1:0] sender;
    logic                 last;
  } req_t;

  typedef struct packed {
    logic [NODE_BITS:0] fwd_node;
    logic               reachable;
    logic               updated;
  } rsp_t;

endpackage

// ----- src/prt_slot_enc.sv -----
// ----------------------------------------------------------------------------
// prt_slot_enc
// finds the first digit where an address differs from the own id
// ----------------------------------------------------------------------------
module prt_slot_enc (
  input  logic [prt_pkg::ADDR_W-1:0] addr,
  input  logic [prt_pkg::ADDR_W-1:0] own,
  output logic                       is_self,
  output logic [prt_pkg::SLOT_W-1:0] slot
);

  logic [prt_pkg::ID_W-1:0] a;
  logic [prt_pkg::ID_W-1:0] o;

  assign a = prt_pkg::ID_W'(addr);
  assign o = prt_pkg::ID_W'(own);

  // scan from least significant digit up so the most significant mismatch wins
  always_comb begin
    is_self = 1'b1;
    slot    = '0;
    for (int p = prt_pkg::DIGITS - 1; p >= 0; p--) begin
      if (a[2*(prt_pkg::DIGITS-1-p) +: 2] != o[2*(prt_pkg::DIGITS-1-p) +: 2]) begin
        is_self = 1'b0;
        slot    = prt_pkg::SLOT_W'(p * 4) + prt_pkg::SLOT_W'(a[2*(prt_pkg::DIGITS-1-p) +: 2]);
      end
    end
  end

endmodule

// ----- src/prt_table.sv -----
// ----------------------------------------------------------------------------
// prt_table
// slot storage, offer merge and lookup for the prefix routing table
// ----------------------------------------------------------------------------
module prt_table (
  input  logic          clk,
  input  logic          rst,
  input  prt_pkg::req_t req,
  output prt_pkg::rsp_t rsp
);

  logic [prt_pkg::SLOTS-1:0]     slot_filled;
  logic [prt_pkg::HOP_BITS-1:0]  slot_hops      [prt_pkg::SLOTS];
  logic [prt_pkg::NODE_BITS-1:0] slot_next_node [prt_pkg::SLOTS];
  logic                          merge_closed;

  logic                          filled_s;
  logic [prt_pkg::HOP_BITS-1:0]  hops_s;
  logic [prt_pkg::HOP_SUM_W-1:0] hop_sum;
  logic [prt_pkg::HOP_BITS-1:0]  new_hops;
  logic                          is_offer;
  logic                          do_upd;

  assign filled_s = slot_filled[req.slot];
  assign hops_s   = slot_hops[req.slot];
  assign hop_sum  = prt_pkg::HOP_SUM_W'(req.hops) + prt_pkg::HOP_SUM_W'(1);
  assign new_hops = (hop_sum > prt_pkg::HOP_SAT) ? prt_pkg::HOP_BITS'(prt_pkg::HOP_SAT)
                                                 : prt_pkg::HOP_BITS'(hop_sum);
  assign is_offer = req.valid && (req.action == prt_pkg::ACT_OFFER);
  assign do_upd   = is_offer && req.present && !merge_closed && !req.is_self &&
                    (!filled_s || (new_hops < hops_s));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_filled  <= '0;
      merge_closed <= 1'b0;
    end else begin
      if (do_upd) begin
        slot_filled[req.slot] <= 1'b1;
      end
      // end of table reopens the merge even if this entry updated
      if (is_offer) begin
        if (req.last) begin
          merge_closed <= 1'b0;
        end else if (do_upd) begin
          merge_closed <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_upd) begin
      slot_hops[req.slot]      <= new_hops;
      slot_next_node[req.slot] <= req.sender;
    end
  end

  always_comb begin
    rsp = '0;
    unique case (req.action)
      prt_pkg::ACT_LOOKUP: begin
        rsp.fwd_node  = '1;
        rsp.reachable = 1'b0;
        if (req.is_self) begin
          rsp.reachable = 1'b1;
        end else if (filled_s) begin
          rsp.fwd_node  = {1'b0, slot_next_node[req.slot]};
          rsp.reachable = 1'b1;
        end
      end
      prt_pkg::ACT_OFFER: begin
        rsp.updated = do_upd;
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule

// ----- src/prefix_routing_table.sv -----
// ----------------------------------------------------------------------------
// prefix_routing_table
// base-4 digit prefix routing table with neighbor table merge and lookup
// ----------------------------------------------------------------------------
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   request  | start, busy          | action, target_address, address_present,
//            |                      | offered_hops, sender_node, last_of_table
//   result   | done (one cycle)     | fwd_node, reachable, updated
//   config   | own_id_we            | own_id
//
// one request per cycle, busy stays low; a result is registered after its
// request passes the input register, then slot encode and table access into
// the result register. the single table access per request sets the rate.
// rst clears the slot valid bits, the merge flag and own id.
// the receiver cannot stall; every request gives exactly one result.
// ----------------------------------------------------------------------------
module prefix_routing_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            own_id_we,
  input  logic [prt_pkg::ADDR_W-1:0]      own_id,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic [prt_pkg::ADDR_W-1:0]      target_address,
  input  logic                            address_present,
  input  logic [prt_pkg::HOPS_IN_W-1:0]   offered_hops,
  input  logic [prt_pkg::NODE_BITS-1:0]   sender_node,
  input  logic                            last_of_table,
  output logic                            done,
  output logic signed [prt_pkg::NODE_BITS:0] fwd_node,
  output logic                            reachable,
  output logic                            updated
);

  logic [prt_pkg::ADDR_W-1:0]    own_reg;
  logic                          in_valid;
  prt_pkg::act_t                 in_action;
  logic [prt_pkg::ADDR_W-1:0]    in_addr;
  logic                          in_present;
  logic [prt_pkg::HOPS_IN_W-1:0] in_hops;
  logic [prt_pkg::NODE_BITS-1:0] in_sender;
  logic                          in_last;

  logic                          enc_self;
  logic [prt_pkg::SLOT_W-1:0]    enc_slot;
  prt_pkg::req_t                 req;
  prt_pkg::rsp_t                 rsp;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_reg  <= '0;
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (own_id_we) begin
        own_reg <= own_id;
      end
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_action  <= prt_pkg::act_t'(action);
      in_addr    <= target_address;
      in_present <= address_present;
      in_hops    <= offered_hops;
      in_sender  <= sender_node;
      in_last    <= last_of_table;
    end
    if (in_valid) begin
      fwd_node  <= rsp.fwd_node;
      reachable <= rsp.reachable;
      updated   <= rsp.updated;
    end
  end

  prt_slot_enc u_enc (
    .addr    (in_addr),
    .own     (own_reg),
    .is_self (enc_self),
    .slot    (enc_slot)
  );

  always_comb begin
    req.valid   = in_valid;
    req.action  = in_action;
    req.is_self = enc_self;
    req.slot    = enc_slot;
    req.present = in_present;
    req.hops    = in_hops;
    req.sender  = in_sender;
    req.last    = in_last;
  end

  prt_table u_table (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

endmodule

// ----- src/prt_checker.sv -----
// ----------------------------------------------------------------------------
// prt_checker
// port level checks for the prefix routing table
// ----------------------------------------------------------------------------
module prt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [prt_pkg::NODE_BITS:0]     fwd_node,
  input logic                            reachable,
  input logic                            updated
);

  // a word never reports both a merge change and a lookup hit
  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(updated && reachable))
    else $error("result flags both updated and reachable");

  // an offer that changed a slot carries a zero next hop
  a_upd_zero: assert property (@(posedge clk) disable iff (rst)
    (done && updated) |-> (fwd_node == '0))
    else $error("updated result with nonzero next hop");

  // a negative next hop is always minus one
  a_neg_one: assert property (@(posedge clk) disable iff (rst)
    (done && fwd_node[prt_pkg::NODE_BITS]) |-> (fwd_node == '1))
    else $error("negative next hop other than minus one");

  // each accepted request is followed by its result strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result missing two cycles after request");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind prefix_routing_table prt_checker u_prt_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .fwd_node  (fwd_node),
  .reachable (reachable),
  .updated   (updated)
);

// ----- sim/prefix_routing_table_tb.sv -----
// ----------------------------------------------------------------------------
// prefix_routing_table_tb
// drives offers of neighbor table entries and next hop lookups into the
// routing table, predicts result words from a local copy of the slot table,
// merge flag and own id or takes fixed ones from directed rows, and checks
// each strobed result in order. a directed table comes first, then random
// neighbor tables under several own id settings with request idle gaps.
// ----------------------------------------------------------------------------
module prefix_routing_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOP_LIM   = (1 << prt_pkg::HOP_BITS) - 1;
  localparam int LIMIT     = 500000;
  localparam int N_PHASES  = 6;
  localparam int PHASE_LEN = 200;

  typedef struct packed {
    prt_pkg::act_t                 act;
    logic [prt_pkg::ADDR_W-1:0]    addr;
    logic                          present;
    logic [prt_pkg::HOPS_IN_W-1:0] hops;
    logic [prt_pkg::NODE_BITS-1:0] sender;
    logic                          last;
  } item_t;

  typedef struct packed {
    item_t         it;
    logic          fixed;
    prt_pkg::rsp_t want;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          own_id_we = 1'b0;
  logic [prt_pkg::ADDR_W-1:0]    own_id = '0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          action = 1'b0;
  logic [prt_pkg::ADDR_W-1:0]    target_address = '0;
  logic                          address_present = 1'b0;
  logic [prt_pkg::HOPS_IN_W-1:0] offered_hops = '0;
  logic [prt_pkg::NODE_BITS-1:0] sender_node = '0;
  logic                          last_of_table = 1'b0;
  logic                          done;
  logic signed [prt_pkg::NODE_BITS:0] fwd_node;
  logic                          reachable;
  logic                          updated;

  // local copy of the routing state
  logic                          tbl_filled [prt_pkg::SLOTS];
  logic [prt_pkg::HOP_BITS-1:0]  tbl_hops   [prt_pkg::SLOTS];
  logic [prt_pkg::NODE_BITS-1:0] tbl_next   [prt_pkg::SLOTS];
  logic                          merge_shut;
  logic [prt_pkg::ADDR_W-1:0]    node_id;

  prt_pkg::rsp_t pending_rsp [$];
  dir_row_t      dir_rows    [$];
  int            mismatches = 0;
  int            cycles = 0;

  prefix_routing_table u_top (
    .clk             (clk),
    .rst             (rst),
    .own_id_we       (own_id_we),
    .own_id          (own_id),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .target_address  (target_address),
    .address_present (address_present),
    .offered_hops    (offered_hops),
    .sender_node     (sender_node),
    .last_of_table   (last_of_table),
    .done            (done),
    .fwd_node        (fwd_node),
    .reachable       (reachable),
    .updated         (updated)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("** prefix_routing_table: FAILED **");
      $finish;
    end
  end

  // first differing digit and its value pick the slot, -1 for the own id
  function automatic int slot_for(logic [prt_pkg::ADDR_W-1:0] addr);
    int p;
    int sh;
    for (p = 0; p < prt_pkg::DIGITS; p++) begin
      sh = 2 * (prt_pkg::DIGITS - 1 - p);
      if (addr[sh +: 2] != node_id[sh +: 2]) return p * 4 + int'(addr[sh +: 2]);
    end
    return -1;
  endfunction

  task automatic predict_route(input item_t it, output prt_pkg::rsp_t r);
    int s;
    int nh;
    s = slot_for(it.addr);
    r = '0;
    if (it.act == prt_pkg::ACT_LOOKUP) begin
      r.fwd_node = '1;
      if (s < 0) begin
        r.reachable = 1'b1;
      end else if (tbl_filled[s]) begin
        r.fwd_node  = {1'b0, tbl_next[s]};
        r.reachable = 1'b1;
      end
    end else begin
      if (it.present && !merge_shut && s >= 0) begin
        nh = int'(it.hops) + 1;
        if (nh > HOP_LIM) nh = HOP_LIM;
        if (!tbl_filled[s] || nh < int'(tbl_hops[s])) begin
          tbl_filled[s] = 1'b1;
          tbl_hops[s]   = prt_pkg::HOP_BITS'(nh);
          tbl_next[s]   = it.sender;
          merge_shut    = 1'b1;
          r.updated     = 1'b1;
        end
      end
      if (it.last) merge_shut = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at cycle %0d: %s expected %0h got %0h", cycles, what, want, got);
  endtask

  always @(posedge clk) begin
    prt_pkg::rsp_t w;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("result word with nothing pending", '0,
                        32'({fwd_node, reachable, updated}));
      end else begin
        w = pending_rsp.pop_front();
        if (fwd_node !== w.fwd_node)
          report_mismatch("fwd_node", 32'(w.fwd_node), 32'(fwd_node));
        if (reachable !== w.reachable)
          report_mismatch("reachable", 32'(w.reachable), 32'(reachable));
        if (updated !== w.updated)
          report_mismatch("updated", 32'(w.updated), 32'(updated));
      end
    end
  end

  // request side: hold the word until start meets busy low
  task automatic send_word(input item_t it, input int gap, input logic fixed,
                           input prt_pkg::rsp_t want);
    prt_pkg::rsp_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action          <= it.act;
    target_address  <= it.addr;
    address_present <= it.present;
    offered_hops    <= it.hops;
    sender_node     <= it.sender;
    last_of_table   <= it.last;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    predict_route(it, r);
    pending_rsp.insert(pending_rsp.size(), fixed ? want : r);
  endtask

  function automatic int pick_gap(bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [prt_pkg::HOPS_IN_W-1:0] pick_hops();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return prt_pkg::HOPS_IN_W'($urandom_range(0, 15));
    if (r < 8) return prt_pkg::HOPS_IN_W'($urandom_range(250, 255));
    return prt_pkg::HOPS_IN_W'($urandom_range(0, 255));
  endfunction

  // mostly addresses that share a prefix with the own id, so every slot row is hit
  function automatic logic [prt_pkg::ADDR_W-1:0] gen_addr();
    int r;
    int p;
    int sh;
    logic [31:0] hi_mask;
    logic [31:0] lo_mask;
    logic [31:0] a;
    r = $urandom_range(0, 9);
    if (r == 0) return node_id;
    if (r == 1) return prt_pkg::ADDR_W'($urandom);
    p  = $urandom_range(0, prt_pkg::DIGITS - 1);
    sh = 2 * (prt_pkg::DIGITS - 1 - p);
    lo_mask = (32'd1 << sh) - 1;
    hi_mask = ~((32'd1 << (sh + 2)) - 1);
    a = (32'(node_id) & hi_mask)
      | ((32'(node_id[sh +: 2]) ^ 32'($urandom_range(1, 3))) << sh)
      | ($urandom & lo_mask);
    return a[prt_pkg::ADDR_W-1:0];
  endfunction

  function automatic dir_row_t mk_row(prt_pkg::act_t a, logic [prt_pkg::ADDR_W-1:0] addr,
                                      int pr, logic [prt_pkg::HOPS_IN_W-1:0] h,
                                      logic [prt_pkg::NODE_BITS-1:0] s,
                                      int l, int fx, logic [prt_pkg::NODE_BITS:0] nh,
                                      int rc, int up);
    dir_row_t d;
    d.it.act     = a;
    d.it.addr    = addr;
    d.it.present = 1'(pr);
    d.it.hops    = h;
    d.it.sender  = s;
    d.it.last    = 1'(l);
    d.fixed      = 1'(fx);
    d.want.fwd_node  = nh;
    d.want.reachable = 1'(rc);
    d.want.updated   = 1'(up);
    return d;
  endfunction

  task automatic write_own_id(input logic [prt_pkg::ADDR_W-1:0] v);
    // let the last word drain out of the pipeline first
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    own_id_we <= 1'b1;
    own_id    <= v;
    @(posedge clk);
    node_id = v;
    own_id_we <= 1'b0;
  endtask

  task automatic run_phase(input int budget, input bit no_idle);
    int    sent;
    int    len;
    int    k;
    bit    broken;
    item_t it;
    logic [prt_pkg::NODE_BITS-1:0] who;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        it.act     = prt_pkg::act_t'($urandom_range(0, 1));
        it.addr    = prt_pkg::ADDR_W'($urandom);
        it.present = 1'($urandom_range(0, 1));
        it.hops    = prt_pkg::HOPS_IN_W'($urandom);
        it.sender  = prt_pkg::NODE_BITS'($urandom);
        it.last    = 1'($urandom_range(0, 1));
        send_word(it, pick_gap(no_idle), 1'b0, '0);
        sent++;
      end else begin
        len    = $urandom_range(1, 8);
        who    = prt_pkg::NODE_BITS'($urandom_range(0, (1 << prt_pkg::NODE_BITS) - 1));
        broken = ($urandom_range(0, 9) == 0);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            it.act     = prt_pkg::ACT_LOOKUP;
            it.addr    = gen_addr();
            it.present = 1'($urandom_range(0, 1));
            it.hops    = prt_pkg::HOPS_IN_W'($urandom);
            it.sender  = prt_pkg::NODE_BITS'($urandom);
            it.last    = 1'($urandom_range(0, 1));
            send_word(it, pick_gap(no_idle), 1'b0, '0);
            sent++;
          end
          it.act     = prt_pkg::ACT_OFFER;
          it.addr    = gen_addr();
          it.present = ($urandom_range(0, 7) != 0);
          it.hops    = pick_hops();
          it.sender  = who;
          it.last    = (k == len - 1) && !broken;
          send_word(it, pick_gap(no_idle), 1'b0, '0);
          sent++;
        end
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    int i;
    logic [prt_pkg::ADDR_W-1:0] ids [N_PHASES];

    for (i = 0; i < prt_pkg::SLOTS; i++) begin
      tbl_filled[i] = 1'b0;
      tbl_hops[i]   = '0;
      tbl_next[i]   = '0;
    end
    merge_shut = 1'b0;
    node_id    = '0;

    // own id is zero out of reset
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_LOOKUP, 16'h0000, 0, 8'd0,   10'd0,   0, 1, '1,      1, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 8'd0,   10'd0,   0, 1, '1,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_LOOKUP, 16'h0001, 1, 8'hFF,  10'h3FF, 1, 1, '1,      0, 0));
    // empty entry and own address never update
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_OFFER,  16'h1234, 0, 8'd0,   10'd1,   0, 1, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_OFFER,  16'h0000, 1, 8'd0,   10'd2,   0, 1, '0,      0, 0));
    // hop count saturates, then the rest of the table is shut out
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_OFFER,  16'hFFFF, 1, 8'hFF,  10'h3FF, 0, 1, '0,      0, 1));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_OFFER,  16'h4000, 1, 8'd0,   10'd5,   0, 1, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_OFFER,  16'h4000, 1, 8'd0,   10'd5,   1, 1, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_OFFER,  16'h4000, 1, 8'd0,   10'd5,   1, 1, '0,      0, 1));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_LOOKUP, 16'h4000, 0, 8'd0,   10'd0,   0, 1, 11'd5,   1, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 8'd0,   10'd0,   0, 1, 11'h3FF, 1, 0));
    // equal hops keep the old entry, fewer hops replace it
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_OFFER,  16'hFFFF, 1, 8'd254, 10'd7,   1, 0, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_OFFER,  16'hFFFF, 1, 8'd253, 10'd7,   1, 0, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 8'd0,   10'd0,   0, 0, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_OFFER,  16'h0001, 1, 8'd0,   10'd0,   1, 0, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_LOOKUP, 16'h0001, 0, 8'd0,   10'd0,   0, 0, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_LOOKUP, 16'h0000, 1, 8'hFF,  10'h3FF, 1, 0, '0,      0, 0));
    // a lookup in the middle of a table leaves the merge flag alone
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_OFFER,  16'h8000, 1, 8'd10,  10'd300, 0, 0, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_LOOKUP, 16'h8000, 0, 8'd0,   10'd0,   1, 0, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_OFFER,  16'hC000, 1, 8'd1,   10'd301, 1, 0, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_OFFER,  16'hC000, 1, 8'd1,   10'd301, 1, 0, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_LOOKUP, 16'hFFFE, 0, 8'd0,   10'd0,   0, 0, '0,      0, 0));
    dir_rows.insert(dir_rows.size(),
      mk_row(prt_pkg::ACT_LOOKUP, 16'h2AAA, 0, 8'd0,   10'd0,   0, 0, '0,      0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r])
      send_word(dir_rows[r].it, pick_gap(1'b0), dir_rows[r].fixed, dir_rows[r].want);
    start <= 1'b0;

    ids[0] = 16'hFFFF;
    ids[1] = prt_pkg::ADDR_W'($urandom);
    ids[2] = 16'h0000;
    ids[3] = prt_pkg::ADDR_W'($urandom);
    ids[4] = 16'h5555;
    ids[5] = prt_pkg::ADDR_W'($urandom);
    for (i = 0; i < N_PHASES; i++) begin
      write_own_id(ids[i]);
      run_phase(PHASE_LEN, ($urandom_range(0, 3) == 0));
    end

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** prefix_routing_table: PASSED **");
    end else begin
      $display("** prefix_routing_table: FAILED **");
    end
    $finish;
  end

endmodule

// ----- prefix_routing_table.f -----
src/prt_pkg.sv
src/prt_slot_enc.sv
src/prt_table.sv
src/prefix_routing_table.sv
src/prt_checker.sv
sim/prefix_routing_table_tb.sv
